### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/spi_pkg.sv
// ----------------------------------------------------------------------------
// Sampled power interpolator package
// Widths, codes, state and command types shared by the interpolator modules.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int TIME_W      = 64;
    localparam int POW_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int DIV_STEPS   = POW_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_ORDER_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_RD,
        S_Q_CMP,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_LOAD,
        RES_CUR,
        RES_PREV,
        RES_INTERP
    } t_res_sel;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [TIME_W-1:0] entry_time;
        logic [POW_W-1:0]  entry_power;
        logic [TIME_W-1:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic [POW_W-1:0] power_out;
        logic             status;
    } t_out_item;

    typedef struct packed {
        logic             capture;
        logic             rd_prev_slot;
        logic [IDX_W-1:0] scan_addr;
        logic             ld_write;
        logic             shift_prev;
        logic             interp_setup;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_sum;
        logic             div_step;
        logic             res_load;
        t_res_sel         res_sel;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic in_mode;
        logic q_lt;
        logic out_free;
    } t_sts;

endpackage

### src/spi_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
interface spi_in_if import spi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] entry_time;
    logic [POW_W-1:0]  entry_power;
    logic [TIME_W-1:0] query_time;

    modport source (output valid, mode, entry_index, entry_time, entry_power, query_time,
                    input ready);
    modport sink   (input valid, mode, entry_index, entry_time, entry_power, query_time,
                    output ready);
endinterface

### src/spi_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface spi_out_if import spi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POW_W-1:0] power_out;
    logic             status;

    modport source (output valid, power_out, status, input ready);
    modport sink   (input valid, power_out, status, output ready);
endinterface

### src/spi_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface spi_cfg_if import spi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/spi_ctrl.sv
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences loads, the table scan, multiply and divide; holds the config regs.
// ----------------------------------------------------------------------------
module spi_ctrl import spi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_sts                  i_sts,
    output t_cmd                  o_cmd,
    output t_state                o_state
);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_u, n_u;
    logic [DIV_CNT_W-1:0] r_div, n_div;
    logic                 r_hold;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W-1:0]     u_inc;
    logic                 in_acc;
    logic                 last_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_state     = r_state;
    assign in_acc      = i_in_valid && o_in_ready;

    // zero counts as one, anything past the table saturates
    always_comb begin
        if (r_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_count > CNT_W'(TABLE_DEPTH)) begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end else begin
            n_eff = r_count;
        end
    end

    assign u_inc      = r_u + CNT_W'(1);
    assign last_entry = (u_inc == n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_u     <= '0;
            r_div   <= '0;
            r_hold  <= 1'b0;
            r_count <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            r_div   <= n_div;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HOLD:  r_hold  <= i_cfg_data[0];
                    CFG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_sts.in_mode == MODE_LOAD) ? S_LD_RD : S_Q_RD;
                end
            end
            S_LD_RD:   n_state = S_LD_WR;
            S_LD_WR:   n_state = S_DONE;
            S_Q_RD:    n_state = S_Q_CMP;
            S_Q_CMP: begin
                if (i_sts.q_lt) begin
                    n_state = (r_u == '0 || r_hold) ? S_DONE : S_MUL_LO;
                end else begin
                    n_state = last_entry ? S_DONE : S_Q_RD;
                end
            end
            S_MUL_LO:  n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_MUL_SUM;
            S_MUL_SUM: n_state = S_DIV;
            S_DIV: begin
                if (r_div == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:     n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // scan and divide counters
    always_comb begin
        n_u   = r_u;
        n_div = r_div;
        case (r_state)
            S_IDLE:    n_u   = '0;
            S_Q_CMP:   n_u   = u_inc;
            S_MUL_SUM: n_div = '0;
            S_DIV:     n_div = r_div + DIV_CNT_W'(1);
            default:   ;
        endcase
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.res_sel   = RES_LOAD;
        o_cmd.scan_addr = r_u[IDX_W-1:0];
        case (r_state)
            S_IDLE:    o_cmd.capture      = in_acc;
            S_LD_RD:   o_cmd.rd_prev_slot = 1'b1;
            S_LD_WR: begin
                o_cmd.ld_write = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_LOAD;
            end
            S_Q_CMP: begin
                if (i_sts.q_lt) begin
                    o_cmd.res_load     = (r_u == '0) || r_hold;
                    o_cmd.res_sel      = (r_u == '0) ? RES_CUR : RES_PREV;
                    o_cmd.interp_setup = (r_u != '0) && !r_hold;
                end else begin
                    o_cmd.shift_prev = 1'b1;
                    o_cmd.res_load   = last_entry;
                    o_cmd.res_sel    = RES_CUR;
                end
            end
            S_MUL_LO:  o_cmd.mul_lo   = 1'b1;
            S_MUL_HI:  o_cmd.mul_hi   = 1'b1;
            S_MUL_SUM: o_cmd.mul_sum  = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_INTERP;
            end
            S_DONE:    o_cmd.out_load = i_sts.out_free;
            default:   ;
        endcase
    end

endmodule

### src/spi_dpath.sv
// ----------------------------------------------------------------------------
// Interpolator datapath
// Sample table memory, neighbor registers, shared multiplier, serial divider.
// ----------------------------------------------------------------------------
module spi_dpath import spi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
    logic [POW_W-1:0]  pow_mem  [TABLE_DEPTH];

    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_etime;
    logic [POW_W-1:0]  r_epow;
    logic [TIME_W-1:0] r_qtime;
    logic [TIME_W-1:0] r_rd_time;
    logic [POW_W-1:0]  r_rd_pow;
    logic [TIME_W-1:0] r_prev_time;
    logic [POW_W-1:0]  r_prev_pow;
    logic              r_neg;
    logic [POW_W-1:0]  r_diff;
    logic [POW_W-1:0]  r_base;
    logic [TIME_W-1:0] r_dt;
    logic [TIME_W-1:0] r_span;
    logic [2*POW_W-1:0] r_p0;
    logic [2*POW_W-1:0] r_p1;
    logic [TIME_W-1:0] r_rem;
    logic [POW_W-1:0]  r_dvd;
    logic [POW_W-1:0]  r_quo;
    logic [POW_W-1:0]  r_res_pow;
    logic              r_res_st;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [IDX_W-1:0]         rd_addr;
    logic                     order_err;
    logic                     pr_lt_pl;
    logic [POW_W-1:0]         mul_a;
    logic [2*POW_W-1:0]       mul_p;
    logic [TIME_W+POW_W-1:0]  prod;
    logic [TIME_W:0]          rem_x;
    logic [TIME_W:0]          rem_sub;
    logic                     rem_ge;
    logic [POW_W-1:0]         res_pow;
    logic                     res_st;

    assign rd_addr   = i_cmd.rd_prev_slot ? (r_idx - IDX_W'(1)) : i_cmd.scan_addr;
    assign order_err = (r_idx != '0) && (r_etime <= r_rd_time);
    assign pr_lt_pl  = (r_rd_pow < r_prev_pow);

    assign mul_a = i_cmd.mul_hi ? r_dt[TIME_W-1:POW_W] : r_dt[POW_W-1:0];
    assign mul_p = mul_a * r_diff;
    assign prod  = {{POW_W{1'b0}}, r_p0} + {r_p1, {POW_W{1'b0}}};

    assign rem_x   = {r_rem, r_dvd[POW_W-1]};
    assign rem_sub = rem_x - {1'b0, r_span};
    assign rem_ge  = (rem_x >= {1'b0, r_span});

    always_comb begin
        res_st = ST_OK;
        case (i_cmd.res_sel)
            RES_LOAD: begin
                res_pow = '0;
                res_st  = order_err ? ST_ORDER_ERR : ST_OK;
            end
            RES_CUR:    res_pow = r_rd_pow;
            RES_PREV:   res_pow = r_prev_pow;
            RES_INTERP: res_pow = r_neg ? (r_base - r_quo) : (r_base + r_quo);
            default:    res_pow = '0;
        endcase
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write && !order_err) begin
            time_mem[r_idx] <= r_etime;
            pow_mem[r_idx]  <= r_epow;
        end
        r_rd_time <= time_mem[rd_addr];
        r_rd_pow  <= pow_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx   <= i_item.entry_index;
            r_etime <= i_item.entry_time;
            r_epow  <= i_item.entry_power;
            r_qtime <= i_item.query_time;
        end
        if (i_cmd.shift_prev) begin
            r_prev_time <= r_rd_time;
            r_prev_pow  <= r_rd_pow;
        end
        // left neighbor is the previous entry, right neighbor the one just read
        if (i_cmd.interp_setup) begin
            r_neg  <= pr_lt_pl;
            r_diff <= pr_lt_pl ? (r_prev_pow - r_rd_pow) : (r_rd_pow - r_prev_pow);
            r_base <= r_prev_pow;
            r_dt   <= r_qtime - r_prev_time;
            r_span <= r_rd_time - r_prev_time;
        end
        if (i_cmd.mul_lo) begin
            r_p0 <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_p1 <= mul_p;
        end
        // quotient fits in 32 bits, so the upper 64 dividend bits start as remainder
        if (i_cmd.mul_sum) begin
            r_rem <= prod[TIME_W+POW_W-1:POW_W];
            r_dvd <= prod[POW_W-1:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[TIME_W-1:0] : rem_x[TIME_W-1:0];
            r_dvd <= {r_dvd[POW_W-2:0], 1'b0};
            r_quo <= {r_quo[POW_W-2:0], rem_ge};
        end
        if (i_cmd.res_load) begin
            r_res_pow <= res_pow;
            r_res_st  <= res_st;
        end
        if (i_cmd.out_load) begin
            r_out_item.power_out <= r_res_pow;
            r_out_item.status    <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.in_mode  = i_item.mode;
    assign o_sts.q_lt     = (r_qtime < r_rd_time);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### src/sampled_power_interpolator.sv
// ----------------------------------------------------------------------------
// Sampled power interpolator
// Table of timestamped power samples answering piecewise-linear power queries.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the result waits in an output register, so
// the next item is taken while it is unread. A load reads the previous slot,
// writes the entry and hands off its status. A query scans the table linearly
// through the single read port of the sample memory, reading and comparing one
// entry at a time, k entries for a right neighbor at index k-1, up to the
// configured sample count. A clamped or held answer is handed off after the
// scan; an interpolated one goes on through two 32x32 partial products, a
// 96-bit sum, a 32-step restoring divide and a final add or subtract.
// Configuration writes are always taken and apply from the next cycle.
// The table memory has no clearing pass; reading an unloaded slot is undefined.
`include "assert_macros.svh"

module sampled_power_interpolator import spi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spi_in_if.sink        i_in_ch,
    spi_out_if.source     o_out_ch,
    spi_cfg_if.sink       i_cfg_ch
);

    t_cmd      cmd;
    t_sts      sts;
    t_state    state;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;
    logic      cfg_ready;
    logic      out_valid;

    assign in_item.mode        = i_in_ch.mode;
    assign in_item.entry_index = i_in_ch.entry_index;
    assign in_item.entry_time  = i_in_ch.entry_time;
    assign in_item.entry_power = i_in_ch.entry_power;
    assign in_item.query_time  = i_in_ch.query_time;

    assign i_in_ch.ready      = in_ready;
    assign i_cfg_ch.ready     = cfg_ready;
    assign o_out_ch.valid     = out_valid;
    assign o_out_ch.power_out = out_item.power_out;
    assign o_out_ch.status    = out_item.status;

    spi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (in_ready),
        .i_cfg_valid (i_cfg_ch.valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (i_cfg_ch.index),
        .i_cfg_data  (i_cfg_ch.data),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    spi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    // an accepted beat keeps the input closed until its result is handed off
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_ch.valid && in_ready, !in_ready)
    // the output register is loaded only when its previous beat is gone
    `ASSERT_IMPLIES(a_out_load_free, i_clk, i_rst_n, cmd.out_load, !out_valid || o_out_ch.ready)
    // a rejected load reports no power
    `ASSERT_IMPLIES(a_err_zero_pow, i_clk, i_rst_n, out_valid && out_item.status, out_item.power_out == '0)
    // a result reaches the output register only from the hand-off state
    `ASSERT_IMPLIES(a_load_in_done, i_clk, i_rst_n, cmd.out_load, state == S_DONE)

endmodule
